>>> src/rbd_pkg.sv
// Shared types and constants for the 2x2 RGB box downsampler.
// No dependencies; used by every module in src.
package rbd_pkg;

	localparam int unsigned CFG_W        = 13;
	localparam int unsigned MAX_WIDTH    = 4096;
	localparam int unsigned HEIGHT_LIMIT = 4096;
	localparam int unsigned ROW_W        = 12;
	localparam int unsigned CH_W         = 8;
	localparam int unsigned PAIR_W       = CH_W + 1;

	localparam logic REG_SRC_WIDTH  = 1'b0;
	localparam logic REG_SRC_HEIGHT = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic            end_of_row;
		logic            end_of_frame;
	} pix_out_t;

	typedef struct packed {
		logic [PAIR_W-1:0] red;
		logic [PAIR_W-1:0] green;
		logic [PAIR_W-1:0] blue;
	} pair_sum_t;

	// Position flags of the pixel at the head of the raster
	typedef struct packed {
		logic odd_col;
		logic odd_row;
		logic end_of_row;
		logic end_of_frame;
	} pos_t;

endpackage

>>> src/rgb_box_downsample_2x2.sv
// 2x2 box-filter downsampler for an RGB888 raster stream.
// Pipeline: store read and stage register, then result register, from input transfer to result valid.
// Throughput: one source pixel per cycle while the output is not stalled; one result per pair on odd rows.
// Reset: counters cleared and size registers set to 256 x 256 at once; line store is not cleared.
// Depends on rbd_pkg, rbd_raster and rbd_line_store.
module rgb_box_downsample_2x2 #(
	parameter int unsigned MAX_WIDTH = rbd_pkg::MAX_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [rbd_pkg::CFG_W-1:0] cfg_data,
	input  logic                      src_valid,
	output logic                      src_ready,
	input  rbd_pkg::pix_in_t          src_data,
	output logic                      dst_valid,
	input  logic                      dst_ready,
	output rbd_pkg::pix_out_t         dst_data
);

	localparam int unsigned AW = $clog2(MAX_WIDTH) - 1;
	localparam int unsigned PW = rbd_pkg::PAIR_W;

	logic [rbd_pkg::CFG_W-1:0] src_width_q;
	logic [rbd_pkg::CFG_W-1:0] src_height_q;
	logic                      accept;
	logic [AW-1:0]             idx;
	rbd_pkg::pos_t             pos;
	rbd_pkg::pix_in_t          even_px_q;
	rbd_pkg::pair_sum_t        pair_sum;
	rbd_pkg::pair_sum_t        stored_sum;
	logic                      valid_s1;
	rbd_pkg::pos_t             pos_s1;
	rbd_pkg::pair_sum_t        pair_s1;
	logic                      emit_s1;
	logic                      s1_go;
	logic                      out_free;
	logic [PW:0]               block_red;
	logic [PW:0]               block_green;
	logic [PW:0]               block_blue;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= rbd_pkg::CFG_W'(256);
			src_height_q <= rbd_pkg::CFG_W'(256);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rbd_pkg::REG_SRC_WIDTH: begin
					src_width_q <= cfg_data;
				end
				rbd_pkg::REG_SRC_HEIGHT: begin
					src_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_free  = !dst_valid || dst_ready;
	assign emit_s1   = pos_s1.odd_col && pos_s1.odd_row;
	assign s1_go     = !valid_s1 || !emit_s1 || out_free;
	assign src_ready = s1_go;
	assign accept    = src_valid && src_ready;

	rbd_raster #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.src_width (src_width_q),
		.src_height(src_height_q),
		.idx       (idx),
		.pos       (pos)
	);

	// Horizontal pair sum of the held even pixel and the incoming odd pixel
	assign pair_sum.red   = {1'b0, even_px_q.in_red}   + {1'b0, src_data.in_red};
	assign pair_sum.green = {1'b0, even_px_q.in_green} + {1'b0, src_data.in_green};
	assign pair_sum.blue  = {1'b0, even_px_q.in_blue}  + {1'b0, src_data.in_blue};

	always_ff @(posedge clk) begin
		if (accept && !pos.odd_col) begin
			even_px_q <= src_data;
		end
	end

	rbd_line_store #(
		.AW(AW)
	) u_line_store (
		.clk    (clk),
		.wr_en  (accept && pos.odd_col && !pos.odd_row),
		.wr_addr(idx),
		.wr_data(pair_sum),
		.rd_en  (accept && pos.odd_col && pos.odd_row),
		.rd_addr(idx),
		.rd_data(stored_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_go) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1  <= pos;
			pair_s1 <= pair_sum;
		end
	end

	assign block_red   = {1'b0, stored_sum.red}   + {1'b0, pair_s1.red};
	assign block_green = {1'b0, stored_sum.green} + {1'b0, pair_s1.green};
	assign block_blue  = {1'b0, stored_sum.blue}  + {1'b0, pair_s1.blue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else if (out_free) begin
			dst_valid <= valid_s1 && emit_s1;
		end
	end

	// Load the result register only when a result moves forward
	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && emit_s1) begin
			dst_data.out_red      <= block_red[PW:2];
			dst_data.out_green    <= block_green[PW:2];
			dst_data.out_blue     <= block_blue[PW:2];
			dst_data.end_of_row   <= pos_s1.end_of_row;
			dst_data.end_of_frame <= pos_s1.end_of_frame;
		end
	end

endmodule

>>> src/rbd_line_store.sv
// Line store holding the horizontal pair sums of the last even source row.
// Depends on rbd_pkg for the pair sum type.
module rbd_line_store #(
	parameter int unsigned AW = 11
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  rbd_pkg::pair_sum_t  wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output rbd_pkg::pair_sum_t  rd_data
);

	rbd_pkg::pair_sum_t mem [(1 << AW)];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> src/rbd_raster.sv
// Column and row counters of the source raster, with clamped image limits
// and end-of-row / end-of-frame detection. Depends on rbd_pkg.
module rbd_raster #(
	parameter int unsigned MAX_WIDTH = rbd_pkg::MAX_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [rbd_pkg::CFG_W-1:0]   src_width,
	input  logic [rbd_pkg::CFG_W-1:0]   src_height,
	output logic [$clog2(MAX_WIDTH)-2:0] idx,
	output rbd_pkg::pos_t               pos
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned EW = (CW + 1 > rbd_pkg::CFG_W) ? CW + 1 : rbd_pkg::CFG_W;
	localparam int unsigned RW = rbd_pkg::ROW_W;

	logic [CW-1:0]            col_q;
	logic [RW-1:0]            row_q;
	logic [EW-1:0]            width_ext;
	logic [EW-1:0]            width_eff;
	logic [rbd_pkg::CFG_W-1:0] height_eff;
	logic [CW-1:0]            width_last;
	logic [CW-2:0]            half_width_last;
	logic [RW-1:0]            height_last;
	logic [RW-2:0]            half_height_last;
	logic                     col_end;
	logic                     row_end;

	// Clamp the configured size into the supported range
	always_comb begin
		width_ext = EW'(src_width);
		if (src_width < rbd_pkg::CFG_W'(2)) begin
			width_eff = EW'(2);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			width_eff = EW'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
		if (src_height < rbd_pkg::CFG_W'(2)) begin
			height_eff = rbd_pkg::CFG_W'(2);
		end else if (src_height > rbd_pkg::CFG_W'(rbd_pkg::HEIGHT_LIMIT)) begin
			height_eff = rbd_pkg::CFG_W'(rbd_pkg::HEIGHT_LIMIT);
		end else begin
			height_eff = src_height;
		end
	end

	assign width_last       = CW'(width_eff - EW'(1));
	assign half_width_last  = (CW-1)'((width_eff >> 1) - EW'(1));
	assign height_last      = RW'(height_eff - rbd_pkg::CFG_W'(1));
	assign half_height_last = (RW-1)'((height_eff >> 1) - rbd_pkg::CFG_W'(1));

	assign col_end = col_q >= width_last;
	assign row_end = row_q >= height_last;

	assign idx              = col_q[CW-1:1];
	assign pos.odd_col      = col_q[0];
	assign pos.odd_row      = row_q[0];
	assign pos.end_of_row   = col_q[CW-1:1] == half_width_last;
	assign pos.end_of_frame = pos.end_of_row && (row_q[RW-1:1] == half_height_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule
